[hw/rtl/lnf_pkg.sv]
// ----------------------------------------------------------------------------
// lnf_pkg
// Shared types and constants of the layer normalization forward block.
// ----------------------------------------------------------------------------
package lnf_pkg;

   localparam int MAX_ROW   = 4096;
   localparam int COUNT_W   = 13;
   localparam int DIV_N_W   = 49;
   localparam int DIV_D_W   = 33;
   localparam int DIV_STEP_W = 6;
   localparam int ROOT_W    = 25;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SQ_STEP_W = 5;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [23:0] INV_MAX = 24'hFFFFFF;

   localparam logic [1:0] MODE_MEAN = 2'd0;
   localparam logic [1:0] MODE_VAR  = 2'd1;
   localparam logic [1:0] MODE_NORM = 2'd2;
   localparam logic [1:0] MODE_LOAD = 2'd3;

   localparam logic [1:0] REG_EPSILON      = 2'd0;
   localparam logic [1:0] REG_OUTPUT_SCALE = 2'd1;
   localparam logic [1:0] REG_SCALE_ENABLE = 2'd2;
   localparam logic [1:0] REG_SHIFT_ENABLE = 2'd3;

   localparam logic KIND_ELEMENT = 1'b0;
   localparam logic KIND_STATS   = 1'b1;

   typedef enum logic [1:0] {
      OP_MEAN = 2'd0,
      OP_VAR  = 2'd1,
      OP_NORM = 2'd2,
      OP_LOAD = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] sample;
      logic signed [15:0] scale_value;
      logic signed [15:0] shift_value;
      logic signed [15:0] given_mean;
      logic [31:0]        given_variance;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [15:0] epsilon;
      logic [15:0] output_scale;
      logic        scale_enable;
      logic        shift_enable;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

[hw/rtl/lnf_front.sv]
// ----------------------------------------------------------------------------
// lnf_front
// Input side: takes items, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module lnf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic signed [15:0]  req_sample,
   input  logic signed [15:0]  req_scale_value,
   input  logic signed [15:0]  req_shift_value,
   input  logic signed [15:0]  req_given_mean,
   input  logic [31:0]         req_given_variance,
   input  logic                req_last,
   output logic                item_valid,
   output lnf_pkg::item_type   item,
   input  logic                item_pop
);
   import lnf_pkg::*;

   item_type              queue_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   item_type              new_item;
   logic                  push;
   logic                  pop;

   always_comb begin
      unique case (req_mode)
         MODE_MEAN: new_item.op = OP_MEAN;
         MODE_VAR:  new_item.op = OP_VAR;
         MODE_NORM: new_item.op = OP_NORM;
         MODE_LOAD: new_item.op = OP_LOAD;
         default:   new_item.op = OP_MEAN;
      endcase
      new_item.sample         = req_sample;
      new_item.scale_value    = req_scale_value;
      new_item.shift_value    = req_shift_value;
      new_item.given_mean     = req_given_mean;
      new_item.given_variance = req_given_variance;
      new_item.last           = req_last;
   end

   assign req_stall  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[hw/rtl/lnf_div.sv]
// ----------------------------------------------------------------------------
// lnf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lnf_pkg::div_req_type req,
   output lnf_pkg::div_rsp_type rsp
);
   import lnf_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_D_W:0]      rem_ff, rem_in;
   logic [DIV_N_W-1:0]    quo_ff, quo_in;
   logic [DIV_D_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_D_W:0]      rem_shift;

   always_comb begin
      rem_shift = {rem_ff[DIV_D_W-1:0], quo_ff[DIV_N_W-1]};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dsr_ff}) begin
            rem_in = rem_shift - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[hw/rtl/lnf_sqrt.sv]
// ----------------------------------------------------------------------------
// lnf_sqrt
// Integer square root, digit by digit, one root bit per cycle.
// ----------------------------------------------------------------------------
module lnf_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  lnf_pkg::sqrt_req_type req,
   output lnf_pkg::sqrt_rsp_type rsp
);
   import lnf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SQ_STEP_W-1:0] step_ff, step_in;
   logic [RAD_W-1:0]     rad_ff, rad_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [ROOT_W+2:0]    rem_ff, rem_in;
   logic [ROOT_W+2:0]    rem_shift;
   logic [ROOT_W+2:0]    trial;

   always_comb begin
      rem_shift = {rem_ff[ROOT_W:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = req.radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SQ_STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

[hw/rtl/lnf_back.sv]
// ----------------------------------------------------------------------------
// lnf_back
// Execution side: accumulators, row statistics, normalize datapath, output.
// ----------------------------------------------------------------------------
module lnf_back (
   input  logic               clock,
   input  logic               reset,
   input  lnf_pkg::cfg_type   cfg,
   input  logic               item_valid,
   input  lnf_pkg::item_type  item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_value,
   output logic signed [15:0] rsp_row_mean,
   output logic [31:0]        rsp_row_variance,
   output logic               rsp_end_of_row
);
   import lnf_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_MEAN_PREP = 14'b00000000000010,
      ST_MEAN_WAIT = 14'b00000000000100,
      ST_VAR_PREP  = 14'b00000000001000,
      ST_VAR_WAIT  = 14'b00000000010000,
      ST_ROOT_PREP = 14'b00000000100000,
      ST_ROOT_WAIT = 14'b00000001000000,
      ST_SQRT_WAIT = 14'b00000010000000,
      ST_STATS     = 14'b00000100000000,
      ST_NORM1     = 14'b00001000000000,
      ST_NORM2     = 14'b00010000000000,
      ST_NORM3     = 14'b00100000000000,
      ST_NORM4     = 14'b01000000000000,
      ST_NORM5     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] sum_ff, sum_in;
   logic [47:0]        square_ff, square_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic signed [15:0] mean_ff, mean_in;
   logic [31:0]        variance_ff, variance_in;
   logic [23:0]        inv_ff, inv_in;
   logic               stats_ff, stats_in;

   item_type           cur_ff, cur_in;
   logic signed [41:0] prod1_ff, prod1_in;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [15:0] beta_ff, beta_in;
   logic signed [58:0] prod2_ff, prod2_in;
   logic signed [35:0] norm_ff, norm_in;
   logic signed [52:0] prod3_ff, prod3_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_kind_ff, out_kind_in;
   logic signed [15:0] out_value_ff, out_value_in;
   logic signed [15:0] out_mean_ff, out_mean_in;
   logic [31:0]        out_var_ff, out_var_in;
   logic               out_eor_ff, out_eor_in;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic               out_free;
   logic [COUNT_W-1:0] count_div;
   logic [31:0]        sum_mag;
   logic signed [16:0] dev;
   logic signed [33:0] dev_sq;
   logic signed [16:0] gamma;
   logic signed [18:0] mean_wide;
   logic [32:0]        root_arg;
   logic signed [34:0] norm_round;
   logic signed [44:0] out_round;

   lnf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   lnf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign count_div = (count_ff == '0) ? COUNT_W'(1) : count_ff;
   assign sum_mag   = sum_ff[31] ? 32'(-sum_ff) : sum_ff;
   assign dev       = 17'(item.sample) - 17'(mean_ff);
   assign dev_sq    = dev * dev;
   assign gamma     = cfg.scale_enable ? 17'(cur_ff.scale_value) : 17'sd256;
   assign mean_wide = sum_ff[31] ? -$signed({1'b0, div_rsp.quotient[17:0]})
                                 : $signed({1'b0, div_rsp.quotient[17:0]});
   assign root_arg  = {1'b0, variance_ff} + 33'(cfg.epsilon);
   assign norm_round = 35'((prod2_ff + 59'sd8388608) >>> 24);
   assign out_round  = 45'((prod3_ff + 53'sd128) >>> 8);

   always_comb begin
      state_in    = state_ff;
      sum_in      = sum_ff;
      square_in   = square_ff;
      count_in    = count_ff;
      mean_in     = mean_ff;
      variance_in = variance_ff;
      inv_in      = inv_ff;
      stats_in    = stats_ff;
      cur_in      = cur_ff;
      prod1_in    = prod1_ff;
      diff_in     = diff_ff;
      beta_in     = beta_ff;
      prod2_in    = prod2_ff;
      norm_in     = norm_ff;
      prod3_in    = prod3_ff;
      item_pop    = 1'b0;
      div_req     = '0;
      sqrt_req    = '0;

      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_mean_in  = out_mean_ff;
      out_var_in   = out_var_ff;
      out_eor_in   = out_eor_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               case (item.op)
                  OP_MEAN: begin
                     if (count_ff < COUNT_W'(MAX_ROW)) begin
                        sum_in   = sum_ff + 32'(item.sample);
                        count_in = count_ff + 1'b1;
                     end
                     if (item.last) begin
                        state_in = ST_MEAN_PREP;
                     end
                  end
                  OP_VAR: begin
                     if (count_ff < COUNT_W'(MAX_ROW)) begin
                        square_in = square_ff + {14'b0, dev_sq[33:0]};
                        count_in  = count_ff + 1'b1;
                     end
                     if (item.last) begin
                        state_in = ST_VAR_PREP;
                     end
                  end
                  OP_LOAD: begin
                     mean_in     = item.given_mean;
                     variance_in = item.given_variance;
                     stats_in    = 1'b0;
                     state_in    = ST_ROOT_PREP;
                  end
                  default: begin
                     state_in = ST_NORM1;
                  end
               endcase
            end
         end
         ST_MEAN_PREP: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N_W'(sum_mag) + DIV_N_W'(count_div >> 1);
            div_req.divisor  = DIV_D_W'(count_div);
            state_in         = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient[DIV_N_W-1:15] != '0 && !sum_ff[31]) begin
                  mean_in = 16'sh7FFF;
               end else if (mean_wide < -19'sd32768) begin
                  mean_in = -16'sh8000;
               end else begin
                  mean_in = mean_wide[15:0];
               end
               sum_in   = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_VAR_PREP: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N_W'(square_ff) + DIV_N_W'(count_div >> 1);
            div_req.divisor  = DIV_D_W'(count_div);
            state_in         = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (div_rsp.done) begin
               variance_in = (div_rsp.quotient[DIV_N_W-1:32] != '0) ? 32'hFFFFFFFF
                                                                    : div_rsp.quotient[31:0];
               square_in   = '0;
               count_in    = '0;
               stats_in    = 1'b1;
               state_in    = ST_ROOT_PREP;
            end
         end
         ST_ROOT_PREP: begin
            if (root_arg == '0) begin
               inv_in   = INV_MAX;
               state_in = stats_ff ? ST_STATS : ST_IDLE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N_W'(1) << 48;
               div_req.divisor  = root_arg;
               state_in         = ST_ROOT_WAIT;
            end
         end
         ST_ROOT_WAIT: begin
            if (div_rsp.done) begin
               sqrt_req.start    = 1'b1;
               sqrt_req.radicand = RAD_W'(div_rsp.quotient);
               state_in          = ST_SQRT_WAIT;
            end
         end
         ST_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               inv_in   = sqrt_rsp.root[ROOT_W-1] ? INV_MAX : sqrt_rsp.root[23:0];
               state_in = stats_ff ? ST_STATS : ST_IDLE;
            end
         end
         ST_STATS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_STATS;
               out_value_in = '0;
               out_mean_in  = mean_ff;
               out_var_in   = variance_ff;
               out_eor_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_NORM1: begin
            prod1_in = gamma * $signed({1'b0, inv_ff});
            diff_in  = 17'(cur_ff.sample) - 17'(mean_ff);
            beta_in  = cfg.shift_enable ? cur_ff.shift_value : 16'sd0;
            state_in = ST_NORM2;
         end
         ST_NORM2: begin
            prod2_in = prod1_ff * diff_ff;
            state_in = ST_NORM3;
         end
         ST_NORM3: begin
            norm_in  = 36'(norm_round) + 36'(beta_ff);
            state_in = ST_NORM4;
         end
         ST_NORM4: begin
            prod3_in = norm_ff * $signed({1'b0, cfg.output_scale});
            state_in = ST_NORM5;
         end
         ST_NORM5: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_ELEMENT;
               if (out_round > 45'sd32767) begin
                  out_value_in = 16'sh7FFF;
               end else if (out_round < -45'sd32768) begin
                  out_value_in = -16'sh8000;
               end else begin
                  out_value_in = out_round[15:0];
               end
               out_mean_in = '0;
               out_var_in  = '0;
               out_eor_in  = cur_ff.last;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         square_ff    <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         variance_ff  <= '0;
         inv_ff       <= '0;
         stats_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         square_ff    <= square_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         variance_ff  <= variance_in;
         inv_ff       <= inv_in;
         stats_ff     <= stats_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prod1_ff     <= prod1_in;
      diff_ff      <= diff_in;
      beta_ff      <= beta_in;
      prod2_ff     <= prod2_in;
      norm_ff      <= norm_in;
      prod3_ff     <= prod3_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_mean_ff  <= out_mean_in;
      out_var_ff   <= out_var_in;
      out_eor_ff   <= out_eor_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_row_mean     = out_mean_ff;
   assign rsp_row_variance = out_var_ff;
   assign rsp_end_of_row   = out_eor_ff;

endmodule

[hw/rtl/layer_norm_forward.sv]
// ----------------------------------------------------------------------------
// layer_norm_forward
// Layer normalization, forward direction, one row streamed in three passes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one element per transfer (valid high, stall low). Send the
//   row with mode 0 to form the mean, then with mode 1 to form the variance
//   (one statistics result at the last element), then with mode 2 to get one
//   normalized element per transfer. Mode 3 loads a given mean and variance.
//   rsp_* presents results through an output register; hold rsp_stall high to
//   keep a result in place, and the block backs up into a four-entry queue
//   before raising req_stall.
//   Back end: mean and variance elements are accumulated as they are popped;
//   a normalize element passes through the pop, four multiply/round stages
//   and the output write before the next item is taken. The end of the mean
//   pass runs one pass of the 49-step divider. The end of the variance pass
//   runs the 49-step variance divide, the 49-step reciprocal divide and the
//   25-step root, all one bit per cycle; a mode 3 load skips the variance
//   divide.
//   Reset is synchronous: it clears the queue, the accumulators, the row
//   statistics and the output register, and loads the register defaults.
//   Registers (APB, word addresses): 0 epsilon, 1 output_scale,
//   2 scale_enable, 3 shift_enable. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module layer_norm_forward (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_sample,
   input  logic signed [15:0] req_scale_value,
   input  logic signed [15:0] req_shift_value,
   input  logic signed [15:0] req_given_mean,
   input  logic [31:0]        req_given_variance,
   input  logic               req_last,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_value,
   output logic signed [15:0] rsp_row_mean,
   output logic [31:0]        rsp_row_variance,
   output logic               rsp_end_of_row,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import lnf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_write;
   logic     item_valid;
   logic     item_pop;
   item_type item;

   // Register file: write on the access phase of an APB transfer.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            REG_EPSILON:      cfg_in.epsilon      = pwdata[15:0];
            REG_OUTPUT_SCALE: cfg_in.output_scale = pwdata[15:0];
            REG_SCALE_ENABLE: cfg_in.scale_enable = pwdata[0];
            REG_SHIFT_ENABLE: cfg_in.shift_enable = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back the register selected by the address.
   always_comb begin
      unique case (paddr[3:2])
         REG_EPSILON:      prdata = {16'b0, cfg_ff.epsilon};
         REG_OUTPUT_SCALE: prdata = {16'b0, cfg_ff.output_scale};
         REG_SCALE_ENABLE: prdata = {31'b0, cfg_ff.scale_enable};
         REG_SHIFT_ENABLE: prdata = {31'b0, cfg_ff.shift_enable};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.epsilon      <= 16'd1;
         cfg_ff.output_scale <= 16'd256;
         cfg_ff.scale_enable <= 1'b0;
         cfg_ff.shift_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: take each transfer, decode it and queue it.
   lnf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_sample         (req_sample),
      .req_scale_value    (req_scale_value),
      .req_shift_value    (req_shift_value),
      .req_given_mean     (req_given_mean),
      .req_given_variance (req_given_variance),
      .req_last           (req_last),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop)
   );

   // Back end: advance accumulators and statistics, drive the output register.
   lnf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_row_mean     (rsp_row_mean),
      .rsp_row_variance (rsp_row_variance),
      .rsp_end_of_row   (rsp_end_of_row)
   );

endmodule
